>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the ramp generator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define SPR_ASSERT_ALW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/spr_pkg.sv
// ---------------------------------------------------------------------------
// spr_pkg
// shared widths, codes, reset values and bundles of the step ramp generator
// ---------------------------------------------------------------------------
package spr_pkg;

   localparam int DELAY_W    = 25;
   localparam int ACCEL_W    = 24;
   localparam int REQ_W      = 2;
   localparam int TARGET_W   = 32;
   localparam int POS_OUT_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   // reset values of the configuration registers
   localparam logic [DELAY_W-1:0] RST_START_PERIOD = 25'd19000000;
   localparam logic [DELAY_W-1:0] RST_MIN_PERIOD   = 25'd2000000;
   localparam logic [ACCEL_W-1:0] RST_ACCEL_STEP   = 24'd10000;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_SLOT     = 2'd0,
      REQ_SET_DEST = 2'd1,
      REQ_SET_HOME = 2'd2
   } req_code_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_PERIOD = 2'd0,
      CSR_MIN_PERIOD   = 2'd1,
      CSR_ACCEL_STEP   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DELAY_W-1:0] start_period;
      logic [DELAY_W-1:0] min_period;
      logic [ACCEL_W-1:0] accel_step;
   } cfg_type;

   typedef struct packed {
      logic                        step;
      logic                        dir_forward;
      logic [DELAY_W-1:0]          delay_ns;
      logic signed [POS_OUT_W-1:0] position_now;
   } result_type;

endpackage

>>> design/spr_if.sv
// ---------------------------------------------------------------------------
// spr_req_if / spr_rsp_if
// valid/ready channels for requests and step results
// ---------------------------------------------------------------------------
interface spr_req_if;
   import spr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [REQ_W-1:0]           req_type;
   logic signed [TARGET_W-1:0] target;

   modport source (output valid, req_type, target, input ready);
   modport sink   (input valid, req_type, target, output ready);
endinterface

interface spr_rsp_if;
   import spr_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        step;
   logic                        dir_forward;
   logic [DELAY_W-1:0]          delay_ns;
   logic signed [POS_OUT_W-1:0] position_now;

   modport source (output valid, step, dir_forward, delay_ns, position_now, input ready);
   modport sink   (input valid, step, dir_forward, delay_ns, position_now, output ready);
endinterface

>>> design/spr_csr.sv
// ---------------------------------------------------------------------------
// spr_csr
// configuration registers: start period, minimum period, acceleration step
// ---------------------------------------------------------------------------
module spr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [spr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output spr_pkg::cfg_type                  cfg
);
   import spr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_PERIOD: cfg_in.start_period = csr_wdata[DELAY_W-1:0];
            CSR_MIN_PERIOD:   cfg_in.min_period   = csr_wdata[DELAY_W-1:0];
            CSR_ACCEL_STEP:   cfg_in.accel_step   = csr_wdata[ACCEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_period <= RST_START_PERIOD;
         cfg_ff.min_period   <= RST_MIN_PERIOD;
         cfg_ff.accel_step   <= RST_ACCEL_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/spr_core.sv
// ---------------------------------------------------------------------------
// spr_core
// motion state and the single-pass update for one transaction
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spr_core #(
   parameter int POSITION_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spr_pkg::cfg_type                    cfg,
   input  logic                                fire,
   input  logic [spr_pkg::REQ_W-1:0]           req_type,
   input  logic signed [spr_pkg::TARGET_W-1:0] target,
   output spr_pkg::result_type                 res
);
   import spr_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam int DW = (PB > DELAY_W) ? PB : DELAY_W;
   localparam int PW = DELAY_W + ACCEL_W;

   typedef logic [PB-1:0] pos_type;

   pos_type            position_ff, position_in;
   pos_type            destination_ff, destination_in;
   pos_type            plan_index_ff, plan_index_in;
   pos_type            plan_length_ff, plan_length_in;
   logic               fwd_ff, fwd_in;
   logic               reversing_ff, reversing_in;
   logic [DELAY_W-1:0] next_delay_ff, next_delay_in;
   logic [DELAY_W-1:0] last_delay_ff, last_delay_in;

   // replan after set destination, measured from the current position
   pos_type            tgt_pos;
   logic               rp_same, rp_fwd, rp_rev;
   pos_type            rp_len;

   // position after a step and the approach planned from there
   pos_type            pos_step;
   logic               ap_same, ap_fwd;
   pos_type            ap_len;

   // delay of a slowdown step
   logic [DELAY_W:0]   slow_sum;
   logic               slow_done;

   // head of the ramp: speeding up
   logic               in_head;
   logic [DELAY_W-1:0] accel_ext;
   logic [DELAY_W-1:0] ramp_sub;
   logic [DELAY_W-1:0] head_e;

   // tail of the ramp: slowing down toward the destination
   pos_type            tail_d;
   logic [DW-1:0]      tail_ext;
   logic               tail_big;
   logic [PW-1:0]      tail_prod;
   logic [DELAY_W-1:0] tail_sub;
   logic [DELAY_W-1:0] tail_e;
   logic [PB:0]        idx_inc;

   logic               stepped;

   assign tgt_pos = PB'(target);
   assign rp_same = position_ff == tgt_pos;
   assign rp_fwd  = !($signed(position_ff) > $signed(tgt_pos));
   assign rp_rev  = !rp_same && (rp_fwd != fwd_ff) && (next_delay_ff < cfg.start_period);
   assign rp_len  = rp_fwd ? (tgt_pos - position_ff) : (position_ff - tgt_pos);

   assign pos_step = fwd_ff ? (position_ff + 1'b1) : (position_ff - 1'b1);
   assign ap_same  = pos_step == destination_ff;
   assign ap_fwd   = !($signed(pos_step) > $signed(destination_ff));
   assign ap_len   = ap_fwd ? (destination_ff - pos_step) : (pos_step - destination_ff);

   assign slow_sum  = {1'b0, next_delay_ff} + (DELAY_W + 1)'(cfg.accel_step);
   assign slow_done = (cfg.accel_step == '0) || (slow_sum > {1'b0, cfg.start_period});

   assign accel_ext = DELAY_W'(cfg.accel_step);
   assign in_head   = plan_index_ff < (plan_length_ff >> 1);
   assign ramp_sub  = (next_delay_ff > accel_ext) ? (next_delay_ff - accel_ext) : '0;
   assign head_e    = (plan_index_ff == '0) ? next_delay_ff :
                      ((ramp_sub > cfg.min_period) ? ramp_sub : cfg.min_period);

   // steps left after this one; counts past the delay range saturate to top speed
   assign tail_d    = (plan_index_ff < plan_length_ff) ?
                      (plan_length_ff - 1'b1 - plan_index_ff) : '0;
   assign tail_ext  = DW'(tail_d);
   assign tail_big  = (tail_ext >> DELAY_W) != '0;
   assign tail_prod = tail_ext[DELAY_W-1:0] * cfg.accel_step;
   assign tail_sub  = cfg.start_period - tail_prod[DELAY_W-1:0];
   always_comb begin
      if (((cfg.accel_step != '0) && tail_big) || (tail_prod > PW'(cfg.start_period)))
         tail_e = cfg.min_period;
      else
         tail_e = (tail_sub > cfg.min_period) ? tail_sub : cfg.min_period;
   end

   assign idx_inc = {1'b0, plan_index_ff} + 1'b1;

   // next state for the transaction in the input register
   always_comb begin
      position_in    = position_ff;
      destination_in = destination_ff;
      plan_index_in  = plan_index_ff;
      plan_length_in = plan_length_ff;
      fwd_in         = fwd_ff;
      reversing_in   = reversing_ff;
      next_delay_in  = next_delay_ff;
      last_delay_in  = last_delay_ff;
      stepped        = 1'b0;

      case (req_type)
         REQ_SET_DEST: begin
            destination_in = tgt_pos;
            plan_index_in  = '0;
            if (rp_rev) begin
               reversing_in   = 1'b1;
               plan_length_in = '0;
            end else begin
               reversing_in = 1'b0;
               if (rp_same) begin
                  plan_length_in = '0;
               end else begin
                  fwd_in         = rp_fwd;
                  plan_length_in = rp_len;
               end
            end
         end
         REQ_SET_HOME: begin
            position_in    = '0;
            destination_in = '0;
            reversing_in   = 1'b0;
            plan_index_in  = '0;
            plan_length_in = '0;
         end
         REQ_SLOT: begin
            if (position_ff != destination_ff) begin
               stepped     = 1'b1;
               position_in = pos_step;
               if (reversing_ff) begin
                  last_delay_in = next_delay_ff;
                  next_delay_in = (slow_sum > {1'b0, cfg.start_period}) ?
                                  cfg.start_period : slow_sum[DELAY_W-1:0];
                  if (slow_done) begin
                     reversing_in  = 1'b0;
                     plan_index_in = '0;
                     if (ap_same) begin
                        plan_length_in = '0;
                     end else begin
                        fwd_in         = ap_fwd;
                        plan_length_in = ap_len;
                     end
                  end
               end else begin
                  last_delay_in = in_head ? head_e : tail_e;
                  next_delay_in = last_delay_in;
                  if (idx_inc < {1'b0, plan_length_ff})
                     plan_index_in = idx_inc[PB-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         destination_ff <= '0;
         plan_index_ff  <= '0;
         plan_length_ff <= '0;
         fwd_ff         <= 1'b1;
         reversing_ff   <= 1'b0;
         next_delay_ff  <= RST_START_PERIOD;
         last_delay_ff  <= RST_MIN_PERIOD;
      end else if (fire) begin
         position_ff    <= position_in;
         destination_ff <= destination_in;
         plan_index_ff  <= plan_index_in;
         plan_length_ff <= plan_length_in;
         fwd_ff         <= fwd_in;
         reversing_ff   <= reversing_in;
         next_delay_ff  <= next_delay_in;
         last_delay_ff  <= last_delay_in;
      end
   end

   // result of the transaction
   assign res.step         = stepped;
   assign res.dir_forward  = fwd_in;
   assign res.delay_ns     = last_delay_in;
   assign res.position_now = POS_OUT_W'($signed(position_in));

   // a slowdown carries no plan of its own
   `SPR_ASSERT_IMP(a_rev_no_plan, clock, reset, reversing_ff,
      (plan_index_ff == '0) && (plan_length_ff == '0))

   // the plan index stays inside the plan
   `SPR_ASSERT_ALW(a_index_in_plan, clock, reset,
      (plan_index_ff == '0) || (plan_index_ff < plan_length_ff))

   // every issued step moves the position by one in the old direction
   `SPR_ASSERT_NXT(a_step_moves, clock, reset, fire && res.step,
      position_ff == ($past(fwd_ff) ? ($past(position_ff) + 1'b1) :
                                      ($past(position_ff) - 1'b1)))

endmodule

>>> design/stepper_ramp_profile_generator_top.sv
// ---------------------------------------------------------------------------
// stepper_ramp_profile_generator_top
// trapezoidal step timing generator for a stepper motor
// ---------------------------------------------------------------------------
// Each request transaction (step slot, set destination, set home) passes an
// input register, is resolved combinationally against the motion state and
// lands in an output register, so a new transaction is taken every clock cycle
// while rsp is not stalled. Its result is offered on the rsp channel once it
// sits in the output register; rsp backpressure stalls both stages. The
// per-cycle path is set by the deceleration tail, one 25 x 24 bit multiply of
// the steps left by the acceleration step, followed by a compare against the
// start period. Configuration writes take effect on the next cycle and should
// be made only while no transaction is in flight.
`include "assert_macros.svh"

module stepper_ramp_profile_generator_top #(
   parameter int POSITION_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   spr_req_if.sink                        req_if,
   spr_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [spr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spr_pkg::*;

   cfg_type                    cfg;
   result_type                 core_res;

   logic                       s1_valid_ff, s1_valid_in;
   logic [REQ_W-1:0]           s1_type_ff;
   logic signed [TARGET_W-1:0] s1_target_ff;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_ff;

   logic                       out_free;
   logic                       s1_adv;
   logic                       req_fire;

   spr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spr_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (s1_adv),
      .req_type (s1_type_ff),
      .target   (s1_target_ff),
      .res      (core_res)
   );

   // pipeline flow control
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff   <= req_if.req_type;
         s1_target_ff <= req_if.target;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ff <= core_res;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.step         = out_ff.step;
   assign rsp_if.dir_forward  = out_ff.dir_forward;
   assign rsp_if.delay_ns     = out_ff.delay_ns;
   assign rsp_if.position_now = out_ff.position_now;

   // a stalled input stage keeps its transaction
   `SPR_ASSERT_NXT(a_s1_holds, clock, reset, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_type_ff) && $stable(s1_target_ff))

   // the input stage only advances into a free output register
   `SPR_ASSERT_IMP(a_adv_free, clock, reset, s1_adv, out_free && s1_valid_ff)

   // a stalled response keeps its transaction
   `SPR_ASSERT_NXT(a_out_holds, clock, reset, out_valid_ff && !rsp_if.ready,
      out_valid_ff && $stable(out_ff))

endmodule

>>> tb/sv/tb_stepper_ramp_profile_generator_top.sv
// ---------------------------------------------------------------------------
// tb_stepper_ramp_profile_generator_top
// self-checking bench for the stepper ramp generator: a queue-fed driver sends
// step slots and commands, a shadow motion model predicts every response
// transaction, and the monitor compares responses field by field across
// several register settings, most with random gaps on both channels
// ---------------------------------------------------------------------------
module tb_stepper_ramp_profile_generator_top;
   import spr_pkg::*;

   // request code outside the defined set, must be ignored
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 240;
   localparam int PHASE_COUNT = 7;

   typedef struct {
      logic [REQ_W-1:0]    code;
      logic [TARGET_W-1:0] target;
   } motion_cmd_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   spr_req_if req_bus ();
   spr_rsp_if rsp_bus ();

   stepper_ramp_profile_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   motion_cmd_type pending_cmds[$];
   result_type     expected_steps[$];
   int             fail_count;
   int             phase_items;
   int             gen_dest;
   logic           req_taken;
   logic           steady;

   // shadow registers and motion state
   logic [DELAY_W-1:0]  cfg_start, cfg_min;
   logic [ACCEL_W-1:0]  cfg_accel;
   logic [31:0]         mot_pos, mot_dest, mot_index, mot_length;
   logic                mot_fwd, mot_rev;
   logic [DELAY_W-1:0]  mot_next, mot_last;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic ahead_of(input logic [31:0] a, input logic [31:0] b);
      return $signed(a) > $signed(b);
   endfunction

   function automatic logic [DELAY_W-1:0] larger(input logic [DELAY_W-1:0] a,
                                                 input logic [DELAY_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic take_break();
      return !steady && ($urandom_range(99) < 34);
   endfunction

   // plan a fresh move from the real remaining distance
   function automatic void plan_move();
      mot_rev   = 1'b0;
      mot_index = '0;
      if (mot_pos == mot_dest) begin
         mot_length = '0;
      end else begin
         mot_fwd    = !ahead_of(mot_pos, mot_dest);
         mot_length = mot_fwd ? (mot_dest - mot_pos) : (mot_pos - mot_dest);
      end
   endfunction

   // after a command: slow down first when turning around at speed
   function automatic void retarget();
      logic fwd;
      fwd = !ahead_of(mot_pos, mot_dest);
      if (mot_pos != mot_dest && fwd != mot_fwd && mot_next < cfg_start) begin
         mot_rev    = 1'b1;
         mot_index  = '0;
         mot_length = '0;
      end else begin
         plan_move();
      end
   endfunction

   // deceleration delay with a given number of steps still to go
   function automatic logic [DELAY_W-1:0] brake_delay(input logic [31:0] togo);
      logic [63:0] span;
      if (cfg_accel == '0)
         return larger(cfg_start, cfg_min);
      if (64'(togo) > 64'(cfg_start) / 64'(cfg_accel))
         return cfg_min;
      span = 64'(togo) * 64'(cfg_accel);
      return larger(cfg_start - span[DELAY_W-1:0], cfg_min);
   endfunction

   function automatic void step_once();
      mot_pos = mot_fwd ? mot_pos + 32'd1 : mot_pos - 32'd1;
   endfunction

   // apply one request to the shadow state and return its response
   function automatic result_type advance_motion(input logic [REQ_W-1:0] code,
                                                 input logic [31:0] target);
      result_type         res;
      logic               stepped;
      logic [DELAY_W-1:0] emit;
      logic [DELAY_W:0]   slowed;
      logic [31:0]        idx;
      stepped = 1'b0;
      emit    = '0;
      if (code == REQ_SET_DEST) begin
         mot_dest = target;
         retarget();
      end else if (code == REQ_SET_HOME) begin
         mot_pos  = '0;
         mot_dest = '0;
         retarget();
      end else if (code == REQ_SLOT && mot_pos != mot_dest) begin
         if (mot_rev) begin
            emit = mot_next;
            step_once();
            slowed   = {1'b0, emit} + {2'b0, cfg_accel};
            mot_next = (slowed > {1'b0, cfg_start}) ? cfg_start : slowed[DELAY_W-1:0];
            if (cfg_accel == '0 || slowed > {1'b0, cfg_start})
               plan_move();
         end else begin
            idx = mot_index;
            if (idx < mot_length / 2) begin
               if (idx == 0)
                  emit = mot_next;
               else
                  emit = larger((mot_next > cfg_accel) ? mot_next - cfg_accel : '0, cfg_min);
            end else begin
               emit = brake_delay((idx < mot_length) ? mot_length - 32'd1 - idx : '0);
            end
            step_once();
            mot_next = emit;
            if (33'(idx) + 33'd1 < 33'(mot_length))
               mot_index = idx + 32'd1;
         end
         mot_last = emit;
         stepped  = 1'b1;
      end
      res.step         = stepped;
      res.dir_forward  = mot_fwd;
      res.delay_ns     = mot_last;
      res.position_now = mot_pos;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      motion_cmd_type cmd;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_cmds.size() != 0 && !take_break()) begin
            cmd = pending_cmds.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.req_type <= cmd.code;
            req_bus.target   <= cmd.target;
         end else begin
            req_bus.valid  <= 1'b0;
            req_bus.target <= $urandom;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= !take_break();
   end

   // monitor: check responses, then predict accepted requests
   always @(posedge clock) begin
      result_type want;
      req_taken <= req_bus.valid && req_bus.ready && !reset;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_steps.size() == 0) begin
            $display("%0t: unexpected response transaction, expected none actual %0h",
                     $time, rsp_bus.position_now);
            fail_count++;
         end else begin
            want = expected_steps.pop_front();
            check_field("step", 32'(want.step), 32'(rsp_bus.step));
            check_field("dir_forward", 32'(want.dir_forward), 32'(rsp_bus.dir_forward));
            check_field("delay_ns", 32'(want.delay_ns), 32'(rsp_bus.delay_ns));
            check_field("position_now", want.position_now, rsp_bus.position_now);
         end
      end
      if (!reset && req_bus.valid && req_bus.ready)
         expected_steps.push_back(advance_motion(req_bus.req_type, req_bus.target));
   end

   task automatic push_cmd(input logic [REQ_W-1:0] code, input logic [31:0] target);
      motion_cmd_type cmd;
      cmd.code   = code;
      cmd.target = target;
      pending_cmds.push_back(cmd);
      phase_items++;
   endtask

   task automatic push_slots(input int n);
      repeat (n) push_cmd(REQ_SLOT, $urandom);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_START_PERIOD: cfg_start = val;
         CSR_MIN_PERIOD:   cfg_min   = val;
         CSR_ACCEL_STEP:   cfg_accel = val[ACCEL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_ramp(input int start_ns, input int min_ns, input int accel_ns);
      write_reg(CSR_START_PERIOD, CSR_DATA_W'(start_ns));
      write_reg(CSR_MIN_PERIOD, CSR_DATA_W'(min_ns));
      write_reg(CSR_ACCEL_STEP, CSR_DATA_W'(accel_ns));
   endtask

   // wait until every request is sent and every response checked
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_steps.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // one random stretch of traffic, mostly moves to a new destination
   task automatic gen_move();
      int roll, move_len, off;
      roll = $urandom_range(99);
      if (roll < 70) begin
         move_len = $urandom_range(60, 1);
         off      = $urandom_range(1) ? move_len : -move_len;
         gen_dest += off;
         push_cmd(REQ_SET_DEST, gen_dest);
         if ($urandom_range(99) < 70)
            push_slots(move_len + $urandom_range(40));
         else
            push_slots($urandom_range(move_len, 1));
      end else if (roll < 80) begin
         gen_dest = 0;
         push_cmd(REQ_SET_HOME, $urandom);
         push_slots($urandom_range(10));
      end else if (roll < 88) begin
         push_cmd(REQ_SET_DEST, $urandom);
         push_slots($urandom_range(6, 1));
      end else if (roll < 95) begin
         push_slots($urandom_range(20, 2));
      end else if (roll < 98) begin
         push_cmd(REQ_UNUSED, $urandom);
      end else begin
         push_cmd(REQ_SET_DEST, gen_dest);
      end
   endtask

   // stimulus
   initial begin
      reset            = 1'b1;
      steady           = 1'b0;
      req_taken        = 1'b0;
      fail_count       = 0;
      phase_items      = 0;
      gen_dest         = 0;
      csr_we           = 1'b0;
      csr_index        = CSR_START_PERIOD;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_SLOT;
      req_bus.target   = '0;
      rsp_bus.ready    = 1'b0;
      cfg_start  = RST_START_PERIOD;
      cfg_min    = RST_MIN_PERIOD;
      cfg_accel  = RST_ACCEL_STEP;
      mot_pos    = '0;
      mot_dest   = '0;
      mot_fwd    = 1'b1;
      mot_next   = RST_START_PERIOD;
      mot_last   = RST_MIN_PERIOD;
      mot_index  = '0;
      mot_length = '0;
      mot_rev    = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, idle slot, unused code, short move
      push_cmd(REQ_SLOT, '0);
      push_cmd(REQ_UNUSED, 32'hFFFF_FFFF);
      push_cmd(REQ_SET_DEST, 32'd2);
      push_slots(3);
      push_cmd(REQ_SET_HOME, '0);
      drain();

      // directed: quick ramp, reversal at speed, extreme targets
      set_ramp(100, 20, 10);
      push_cmd(REQ_SET_DEST, 32'd12);
      push_slots(6);
      push_cmd(REQ_SET_DEST, -32'sd4);
      push_slots(4);
      push_cmd(REQ_SET_DEST, 32'h7FFF_FFFF);
      push_slots(1);
      push_cmd(REQ_SET_DEST, 32'h8000_0000);
      push_slots(2);
      push_cmd(REQ_SET_HOME, '0);
      drain();

      // random phases over several ramp settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: set_ramp(1000, 100, 50);
            1: set_ramp(33554431, 1, 16777215);
            2: set_ramp(1, 33554431, 1);
            3: set_ramp(5000, 4000, 1);
            4: set_ramp(33554431, 33554431, 1);
            5: set_ramp(400, 1, 7);
            default: set_ramp($urandom_range(33554431, 1), $urandom_range(33554431, 1),
                              $urandom_range(16777215, 1));
         endcase
         steady      = (p == 3);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS)
            gen_move();
         drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/spr_pkg.sv
design/spr_if.sv
design/spr_csr.sv
design/spr_core.sv
design/stepper_ramp_profile_generator_top.sv
tb/sv/tb_stepper_ramp_profile_generator_top.sv
